### sv/aacc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aacc_pkg;

   localparam int BYTE_W  = 8;
   localparam int COEF_W  = 11;
   localparam int OFFS_W  = 18;
   localparam int PROD_W  = COEF_W + BYTE_W + 1;
   localparam int SUM_W   = PROD_W + 2;
   localparam int NUM_CH  = 3;
   localparam int NUM_BYTES = 4;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // layout codes as written into the layout registers
   localparam logic [2:0] LAYOUT_ARGB = 3'd0;
   localparam logic [2:0] LAYOUT_BGRA = 3'd1;
   localparam logic [2:0] LAYOUT_ABGR = 3'd2;
   localparam logic [2:0] LAYOUT_RGBA = 3'd3;
   localparam logic [2:0] LAYOUT_AYUV = 3'd4;

   // register indexes
   localparam logic [1:0] REG_SOURCE_LAYOUT   = 2'd0;
   localparam logic [1:0] REG_TARGET_LAYOUT   = 2'd1;
   localparam logic [1:0] REG_SOURCE_IS_BT601 = 2'd2;
   localparam logic [1:0] REG_TARGET_IS_BT601 = 2'd3;

   typedef enum logic [2:0] {
      MODE_PASS,
      MODE_REORDER,
      MODE_RGB2YUV,
      MODE_YUV2RGB,
      MODE_REMAT
   } mode_type;

   typedef enum logic [2:0] {
      MAT_Y2R_601,
      MAT_Y2R_709,
      MAT_R2Y_601,
      MAT_R2Y_709,
      MAT_601_TO_709,
      MAT_709_TO_601
   } matrix_sel_type;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [OFFS_W-1:0] offs_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [NUM_BYTES-1:0][BYTE_W-1:0] pixel_type;

   typedef struct packed {
      coef_type [NUM_CH-1:0][NUM_CH-1:0] coef;
      offs_type [NUM_CH-1:0]             offs;
   } matrix_type;

   typedef struct packed {
      logic [2:0] src_layout;
      logic [2:0] dst_layout;
      logic       src_601;
      logic       dst_601;
   } csr_type;

   // decoded pixel, operands and matrix picked
   typedef struct packed {
      logic                           use_mat;
      logic                           clamp;
      logic [1:0]                     place;
      logic [BYTE_W-1:0]              alpha;
      pixel_type                      bypass;
      logic [NUM_CH-1:0][BYTE_W-1:0]  opnd;
      matrix_type                     mat;
      logic                           frame_end;
   } dec_type;

   // products ready for the final sum
   typedef struct packed {
      logic                           use_mat;
      logic                           clamp;
      logic [1:0]                     place;
      logic [BYTE_W-1:0]              alpha;
      pixel_type                      bypass;
      prod_type [NUM_CH-1:0][NUM_CH-1:0] prod;
      offs_type [NUM_CH-1:0]          offs;
      logic                           frame_end;
   } prod_stage_type;

   function automatic matrix_type build_matrix(input int v [12]);
      matrix_type m;
      for (int r = 0; r < NUM_CH; r++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            m.coef[r][c] = COEF_W'(v[r*4 + c]);
         end
         m.offs[r] = OFFS_W'(v[r*4 + 3]);
      end
      return m;
   endfunction

   function automatic matrix_type matrix_of(input matrix_sel_type sel);
      matrix_type m;
      case (sel)
         MAT_Y2R_601: m = build_matrix('{298, 0, 409, -57068,
                                         298, -100, -208, 34707,
                                         298, 516, 0, -70870});
         MAT_Y2R_709: m = build_matrix('{298, 0, 459, -63514,
                                         298, -55, -136, 19681,
                                         298, 541, 0, -73988});
         MAT_R2Y_601: m = build_matrix('{66, 129, 25, 4096,
                                         -38, -74, 112, 32768,
                                         112, -94, -18, 32768});
         MAT_R2Y_709: m = build_matrix('{47, 157, 16, 4096,
                                         -26, -87, 112, 32768,
                                         112, -102, -10, 32768});
         MAT_601_TO_709: m = build_matrix('{256, -30, -53, 10600,
                                            0, 261, 29, -4367,
                                            0, 19, 262, -3289});
         MAT_709_TO_601: m = build_matrix('{256, 25, 49, -9536,
                                            0, 253, -28, 3958,
                                            0, -19, 252, 2918});
         default: m = '0;
      endcase
      return m;
   endfunction

   // byte position of channel ch (0 A, 1 R, 2 G, 3 B) in an rgb layout
   function automatic logic [1:0] pos_of(input logic [1:0] layout, input logic [1:0] ch);
      logic [1:0] p;
      case (layout)
         LAYOUT_ARGB[1:0]: p = ch;
         LAYOUT_BGRA[1:0]: p = 2'd3 - ch;
         LAYOUT_ABGR[1:0]: p = 2'd0 - ch;
         LAYOUT_RGBA[1:0]: p = ch - 2'd1;
         default:          p = ch;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

### sv/argb_ayuv_color_converter_unit.sv
// Pixel converter between the ARGB, BGRA, ABGR, RGBA and AYUV byte layouts.
// Input pixels arrive on the req_ channel and converted pixels leave on the
// rsp_ channel, both valid/ready; one transfer carries one four-byte pixel
// plus its frame end marker, and every input pixel gives exactly one output.
// The csr_ port is a small APB-style register file: source layout (0x0),
// target layout (0x4), source BT.601 flag (0x8), target BT.601 flag (0xC).
// Registers should be written only while no pixel is in flight.
// An accepted input reaches a valid output through three registered stages:
// decode and operand select, then the nine coefficient multiplies, then sum,
// shift, clamp and byte placement into the output register. While rsp_ready
// is high a new pixel can enter every cycle, one pixel per clock.
// When rsp_ready is low the stages behind it keep filling; req_ready drops
// only once all three stages hold a pixel, and nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets both layouts to AYUV and
// both flags to BT.601, so the block passes pixels through unchanged.
`timescale 1ns / 1ps
`default_nettype none

module argb_ayuv_color_converter_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [aacc_pkg::BYTE_W-1:0] req_in_byte0,
   input  wire logic [aacc_pkg::BYTE_W-1:0] req_in_byte1,
   input  wire logic [aacc_pkg::BYTE_W-1:0] req_in_byte2,
   input  wire logic [aacc_pkg::BYTE_W-1:0] req_in_byte3,
   input  wire logic                        req_frame_end_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [aacc_pkg::BYTE_W-1:0]      rsp_out_byte0,
   output logic [aacc_pkg::BYTE_W-1:0]      rsp_out_byte1,
   output logic [aacc_pkg::BYTE_W-1:0]      rsp_out_byte2,
   output logic [aacc_pkg::BYTE_W-1:0]      rsp_out_byte3,
   output logic                             rsp_frame_end_out,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [aacc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [aacc_pkg::DATA_W-1:0] csr_pwdata,
   output logic [aacc_pkg::DATA_W-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import aacc_pkg::*;

   csr_type        csr;
   pixel_type      req_pixel;
   pixel_type      rsp_pixel;
   logic           dec_valid;
   logic           dec_ready;
   dec_type        dec_data;
   logic           mult_valid;
   logic           mult_ready;
   prod_stage_type mult_data;

   assign req_pixel = {req_in_byte3, req_in_byte2, req_in_byte1, req_in_byte0};

   aacc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .csr         (csr)
   );

   aacc_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_pixel     (req_pixel),
      .in_frame_end (req_frame_end_in),
      .out_valid    (dec_valid),
      .out_ready    (dec_ready),
      .out_data     (dec_data)
   );

   aacc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (mult_valid),
      .out_ready (mult_ready),
      .out_data  (mult_data)
   );

   aacc_pack u_pack (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mult_valid),
      .in_ready      (mult_ready),
      .in_data       (mult_data),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_pixel     (rsp_pixel),
      .out_frame_end (rsp_frame_end_out)
   );

   assign rsp_out_byte0 = rsp_pixel[0];
   assign rsp_out_byte1 = rsp_pixel[1];
   assign rsp_out_byte2 = rsp_pixel[2];
   assign rsp_out_byte3 = rsp_pixel[3];

endmodule

`default_nettype wire

### sv/aacc_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module aacc_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [aacc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [aacc_pkg::DATA_W-1:0] csr_pwdata,
   output logic [aacc_pkg::DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready,
   output aacc_pkg::csr_type               csr
);
   import aacc_pkg::*;

   csr_type    csr_ff;
   csr_type    csr_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign reg_index = csr_paddr[3:2];
   assign write_en  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (write_en) begin
         case (reg_index)
            REG_SOURCE_LAYOUT:   csr_in.src_layout = csr_pwdata[2:0];
            REG_TARGET_LAYOUT:   csr_in.dst_layout = csr_pwdata[2:0];
            REG_SOURCE_IS_BT601: csr_in.src_601    = csr_pwdata[0];
            REG_TARGET_IS_BT601: csr_in.dst_601    = csr_pwdata[0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.src_layout <= LAYOUT_AYUV;
         csr_ff.dst_layout <= LAYOUT_AYUV;
         csr_ff.src_601    <= 1'b1;
         csr_ff.dst_601    <= 1'b1;
      end else begin
         csr_ff <= csr_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_SOURCE_LAYOUT:   csr_prdata = DATA_W'(csr_ff.src_layout);
         REG_TARGET_LAYOUT:   csr_prdata = DATA_W'(csr_ff.dst_layout);
         REG_SOURCE_IS_BT601: csr_prdata = DATA_W'(csr_ff.src_601);
         REG_TARGET_IS_BT601: csr_prdata = DATA_W'(csr_ff.dst_601);
         default:             csr_prdata = '0;
      endcase
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

### sv/aacc_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module aacc_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire aacc_pkg::csr_type    csr,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire aacc_pkg::pixel_type  in_pixel,
   input  wire logic                 in_frame_end,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output aacc_pkg::dec_type         out_data
);
   import aacc_pkg::*;

   logic           valid_ff;
   dec_type        data_ff;
   dec_type        data_in;
   mode_type       mode;
   matrix_sel_type mat_sel;
   logic [1:0]     src2;
   logic [1:0]     dst2;

   assign src2 = csr.src_layout[1:0];
   assign dst2 = csr.dst_layout[1:0];

   always_comb begin
      if (csr.src_layout > LAYOUT_AYUV || csr.dst_layout > LAYOUT_AYUV) begin
         mode = MODE_PASS;
      end else if (csr.src_layout == LAYOUT_AYUV && csr.dst_layout == LAYOUT_AYUV) begin
         mode = (csr.src_601 != csr.dst_601) ? MODE_REMAT : MODE_PASS;
      end else if (csr.src_layout == LAYOUT_AYUV) begin
         mode = MODE_YUV2RGB;
      end else if (csr.dst_layout == LAYOUT_AYUV) begin
         mode = MODE_RGB2YUV;
      end else begin
         mode = MODE_REORDER;
      end
   end

   always_comb begin
      case (mode)
         MODE_REMAT:   mat_sel = csr.dst_601 ? MAT_709_TO_601 : MAT_601_TO_709;
         MODE_YUV2RGB: mat_sel = csr.src_601 ? MAT_Y2R_601 : MAT_Y2R_709;
         MODE_RGB2YUV: mat_sel = csr.dst_601 ? MAT_R2Y_601 : MAT_R2Y_709;
         default:      mat_sel = MAT_R2Y_601;
      endcase
   end

   always_comb begin
      data_in           = '0;
      data_in.frame_end = in_frame_end;
      data_in.bypass    = in_pixel;
      data_in.mat       = matrix_of(mat_sel);
      data_in.use_mat   = (mode == MODE_REMAT) || (mode == MODE_YUV2RGB) ||
                          (mode == MODE_RGB2YUV);
      data_in.clamp     = (mode == MODE_YUV2RGB);
      data_in.place     = (mode == MODE_YUV2RGB) ? dst2 : LAYOUT_ARGB[1:0];
      if (mode == MODE_RGB2YUV) begin
         data_in.alpha = in_pixel[pos_of(src2, 2'd0)];
         for (int c = 0; c < NUM_CH; c++) begin
            data_in.opnd[c] = in_pixel[pos_of(src2, 2'(c + 1))];
         end
      end else begin
         data_in.alpha = in_pixel[0];
         for (int c = 0; c < NUM_CH; c++) begin
            data_in.opnd[c] = in_pixel[c + 1];
         end
      end
      if (mode == MODE_REORDER) begin
         for (int i = 0; i < NUM_BYTES; i++) begin
            data_in.bypass[pos_of(dst2, 2'(i))] = in_pixel[pos_of(src2, 2'(i))];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### sv/aacc_mult.sv
`timescale 1ns / 1ps
`default_nettype none

module aacc_mult (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire aacc_pkg::dec_type     in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output aacc_pkg::prod_stage_type   out_data
);
   import aacc_pkg::*;

   logic           valid_ff;
   prod_stage_type data_ff;
   prod_stage_type data_in;

   // nine small products, one per matrix entry
   always_comb begin
      data_in.use_mat   = in_data.use_mat;
      data_in.clamp     = in_data.clamp;
      data_in.place     = in_data.place;
      data_in.alpha     = in_data.alpha;
      data_in.bypass    = in_data.bypass;
      data_in.offs      = in_data.mat.offs;
      data_in.frame_end = in_data.frame_end;
      for (int r = 0; r < NUM_CH; r++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            data_in.prod[r][c] = PROD_W'($signed(in_data.mat.coef[r][c]) *
                                         $signed({1'b0, in_data.opnd[c]}));
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### sv/aacc_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module aacc_pack (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire aacc_pkg::prod_stage_type in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output aacc_pkg::pixel_type           out_pixel,
   output logic                          out_frame_end
);
   import aacc_pkg::*;

   logic                          valid_ff;
   pixel_type                     pixel_ff;
   pixel_type                     pixel_in;
   logic                          frame_end_ff;
   logic signed [SUM_W-1:0]       sum [NUM_CH];
   logic [NUM_CH-1:0][BYTE_W-1:0] chan;

   // sum, floor shift by 8, then clamp or wrap to a byte
   always_comb begin
      for (int r = 0; r < NUM_CH; r++) begin
         sum[r] = SUM_W'(in_data.prod[r][0]) + SUM_W'(in_data.prod[r][1]) +
                  SUM_W'(in_data.prod[r][2]) + SUM_W'(in_data.offs[r]);
         if (!in_data.clamp) begin
            chan[r] = sum[r][BYTE_W+7:8];
         end else if (sum[r][SUM_W-1]) begin
            chan[r] = '0;
         end else if (|sum[r][SUM_W-2:BYTE_W+8]) begin
            chan[r] = '1;
         end else begin
            chan[r] = sum[r][BYTE_W+7:8];
         end
      end
   end

   always_comb begin
      pixel_in = in_data.bypass;
      if (in_data.use_mat) begin
         pixel_in[pos_of(in_data.place, 2'd0)] = in_data.alpha;
         for (int c = 0; c < NUM_CH; c++) begin
            pixel_in[pos_of(in_data.place, 2'(c + 1))] = chan[c];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff     <= pixel_in;
         frame_end_ff <= in_data.frame_end;
      end
   end

   assign out_valid     = valid_ff;
   assign out_pixel     = pixel_ff;
   assign out_frame_end = frame_end_ff;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import aacc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 40;
   localparam int PHASE_PIXELS   = 33;

   typedef struct packed {
      pixel_type px;
      logic      frame_end;
   } pixel_xfer_t;

   logic clock;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   pixel_xfer_t       cur_pixel = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte0;
   logic [BYTE_W-1:0] rsp_out_byte1;
   logic [BYTE_W-1:0] rsp_out_byte2;
   logic [BYTE_W-1:0] rsp_out_byte3;
   logic              rsp_frame_end_out;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   // register mirror, reset values of the block
   logic [2:0] cfg_src_layout = LAYOUT_AYUV;
   logic [2:0] cfg_dst_layout = LAYOUT_AYUV;
   logic       cfg_src_601 = 1'b1;
   logic       cfg_dst_601 = 1'b1;

   pixel_xfer_t pending_pixels[$];
   pixel_xfer_t predicted_pixels[$];
   int          err_count = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   bit          idle_en = 1'b1;

   // rows of coefficients scaled by 256, last entry of each row is the offset
   int color_mat [6][12] = '{
      '{298, 0, 409, -57068, 298, -100, -208, 34707, 298, 516, 0, -70870},
      '{298, 0, 459, -63514, 298, -55, -136, 19681, 298, 541, 0, -73988},
      '{66, 129, 25, 4096, -38, -74, 112, 32768, 112, -94, -18, 32768},
      '{47, 157, 16, 4096, -26, -87, 112, 32768, 112, -102, -10, 32768},
      '{256, -30, -53, 10600, 0, 261, 29, -4367, 0, 19, 262, -3289},
      '{256, 25, 49, -9536, 0, 253, -28, 3958, 0, -19, 252, 2918}
   };

   argb_ayuv_color_converter_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte0      (cur_pixel.px[0]),
      .req_in_byte1      (cur_pixel.px[1]),
      .req_in_byte2      (cur_pixel.px[2]),
      .req_in_byte3      (cur_pixel.px[3]),
      .req_frame_end_in  (cur_pixel.frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte0     (rsp_out_byte0),
      .rsp_out_byte1     (rsp_out_byte1),
      .rsp_out_byte2     (rsp_out_byte2),
      .rsp_out_byte3     (rsp_out_byte3),
      .rsp_frame_end_out (rsp_frame_end_out),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // byte position of channel ch (0 A, 1 R, 2 G, 3 B) in an rgb layout
   function automatic int byte_pos(input logic [2:0] layout, input int ch);
      case (layout)
         LAYOUT_BGRA: return 3 - ch;
         LAYOUT_ABGR: return (4 - ch) % 4;
         LAYOUT_RGBA: return (ch + 3) % 4;
         default:     return ch;
      endcase
   endfunction

   // one matrix row, floor division by 256
   function automatic int mat_row(input matrix_sel_type m, input int row,
                                  input int a, input int b, input int c);
      int s;
      s = color_mat[m][row*4] * a + color_mat[m][row*4+1] * b
          + color_mat[m][row*4+2] * c + color_mat[m][row*4+3];
      return s >>> 8;
   endfunction

   function automatic logic [7:0] clamp8(input int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
   endfunction

   function automatic pixel_xfer_t convert_pixel(input pixel_xfer_t x);
      pixel_xfer_t    y;
      matrix_sel_type m;
      int             ch [4];
      y = x;
      if (cfg_src_layout <= LAYOUT_AYUV && cfg_dst_layout <= LAYOUT_AYUV) begin
         if (cfg_src_layout == LAYOUT_AYUV && cfg_dst_layout == LAYOUT_AYUV) begin
            if (cfg_src_601 != cfg_dst_601) begin
               m = cfg_dst_601 ? MAT_709_TO_601 : MAT_601_TO_709;
               for (int k = 0; k < 3; k++)
                  y.px[k+1] = 8'(mat_row(m, k, x.px[1], x.px[2], x.px[3]));
            end
         end else if (cfg_src_layout == LAYOUT_AYUV) begin
            m = cfg_src_601 ? MAT_Y2R_601 : MAT_Y2R_709;
            y.px[byte_pos(cfg_dst_layout, 0)] = x.px[0];
            for (int k = 0; k < 3; k++)
               y.px[byte_pos(cfg_dst_layout, k+1)] =
                  clamp8(mat_row(m, k, x.px[1], x.px[2], x.px[3]));
         end else if (cfg_dst_layout == LAYOUT_AYUV) begin
            m = cfg_dst_601 ? MAT_R2Y_601 : MAT_R2Y_709;
            for (int k = 0; k < 4; k++)
               ch[k] = x.px[byte_pos(cfg_src_layout, k)];
            y.px[0] = 8'(ch[0]);
            for (int k = 0; k < 3; k++)
               y.px[k+1] = 8'(mat_row(m, k, ch[1], ch[2], ch[3]));
         end else begin
            // same layout with other flags falls out of this as a plain copy
            for (int k = 0; k < 4; k++)
               y.px[byte_pos(cfg_dst_layout, k)] = x.px[byte_pos(cfg_src_layout, k)];
         end
      end
      return y;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (err_count < 40)
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // input side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            predicted_pixels.push_back(convert_pixel(cur_pixel));
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               cur_pixel <= pending_pixels.pop_front();
               req_valid <= 1'b1;
               if (idle_en && $urandom_range(0, 9) == 0)
                  send_gap <= $urandom_range(1, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      pixel_xfer_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_pixels.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_out_byte0, 0);
         end else begin
            want = predicted_pixels.pop_front();
            if (rsp_out_byte0 !== want.px[0])
               report_mismatch("out_byte0", rsp_out_byte0, want.px[0]);
            if (rsp_out_byte1 !== want.px[1])
               report_mismatch("out_byte1", rsp_out_byte1, want.px[1]);
            if (rsp_out_byte2 !== want.px[2])
               report_mismatch("out_byte2", rsp_out_byte2, want.px[2]);
            if (rsp_out_byte3 !== want.px[3])
               report_mismatch("out_byte3", rsp_out_byte3, want.px[3]);
            if (rsp_frame_end_out !== want.frame_end)
               report_mismatch("frame_end_out", rsp_frame_end_out, want.frame_end);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || predicted_pixels.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_SOURCE_LAYOUT:   cfg_src_layout = value[2:0];
         REG_TARGET_LAYOUT:   cfg_dst_layout = value[2:0];
         REG_SOURCE_IS_BT601: cfg_src_601 = value[0];
         REG_TARGET_IS_BT601: cfg_dst_601 = value[0];
         default: ;
      endcase
   endtask

   task automatic set_format(input logic [2:0] src, input logic [2:0] dst,
                             input logic src_601, input logic dst_601);
      wait_idle();
      csr_write(REG_SOURCE_LAYOUT, {29'd0, src});
      csr_write(REG_TARGET_LAYOUT, {29'd0, dst});
      csr_write(REG_SOURCE_IS_BT601, {31'd0, src_601});
      csr_write(REG_TARGET_IS_BT601, {31'd0, dst_601});
      @(negedge clock);
   endtask

   task automatic push_pixel(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic fe);
      pixel_xfer_t p;
      p.px = {b3, b2, b1, b0};
      p.frame_end = fe;
      pending_pixels.push_back(p);
   endtask

   task automatic directed_format(input logic [2:0] src, input logic [2:0] dst,
                                  input logic src_601, input logic dst_601);
      set_format(src, dst, src_601, dst_601);
      push_pixel(8'h00, 8'hFF, 8'h7F, 8'h80, 1'b0);
      push_pixel(8'hFF, 8'h00, 8'h80, 8'h7F, 1'b1);
   endtask

   // extremes come up often so that clamping and wraparound get hit
   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 15))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [2:0] random_layout();
      int r;
      r = $urandom_range(0, 19);
      if (r < 6) return LAYOUT_AYUV;
      if (r < 18) return 3'($urandom_range(LAYOUT_ARGB, LAYOUT_RGBA));
      return 3'($urandom_range(5, 7));
   endfunction

   initial begin : stimulus
      while (reset) @(negedge clock);

      // reset format passes pixels straight through
      push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_pixel(8'h00, 8'hFF, 8'h7F, 8'h80, 1'b0);
      push_pixel(8'hFF, 8'h00, 8'h80, 8'h7F, 1'b1);

      directed_format(LAYOUT_ARGB, LAYOUT_AYUV, 1'b1, 1'b1);
      directed_format(LAYOUT_ABGR, LAYOUT_AYUV, 1'b0, 1'b0);
      directed_format(LAYOUT_AYUV, LAYOUT_BGRA, 1'b1, 1'b1);
      push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      directed_format(LAYOUT_AYUV, LAYOUT_RGBA, 1'b0, 1'b0);
      // re-matrix in both directions
      directed_format(LAYOUT_AYUV, LAYOUT_AYUV, 1'b1, 1'b0);
      directed_format(LAYOUT_AYUV, LAYOUT_AYUV, 1'b0, 1'b1);
      // same rgb layout with differing flags stays untouched
      directed_format(LAYOUT_RGBA, LAYOUT_RGBA, 1'b0, 1'b1);
      directed_format(LAYOUT_BGRA, LAYOUT_ABGR, 1'b1, 1'b1);
      // unknown layout codes on either side
      directed_format(3'd7, LAYOUT_ARGB, 1'b0, 1'b1);
      directed_format(LAYOUT_AYUV, 3'd5, 1'b1, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_format(random_layout(), random_layout(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         idle_en = (p < RANDOM_PHASES - 3) && (p % 5 != 2);
         for (int n = 0; n < PHASE_PIXELS; n++)
            push_pixel(random_byte(), random_byte(), random_byte(), random_byte(),
                       $urandom_range(0, 7) == 0);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (predicted_pixels.size() != 0)
         report_mismatch("missing transfers", 0, predicted_pixels.size());
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### argb_ayuv_color_converter_unit.f
sv/aacc_pkg.sv
sv/aacc_csr.sv
sv/aacc_decode.sv
sv/aacc_mult.sv
sv/aacc_pack.sv
sv/argb_ayuv_color_converter_unit.sv
tb/testbench.sv
